// ===== sv/ncofs_pkg.sv =====
// ----------------------------------------------------------------------------
// ncofs_pkg: shared constants and functions for the NCO frequency shifter
// Widths, phase constants and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package ncofs_pkg;

   // sample and result widths
   localparam int SAMPLE_BITS = 16;
   localparam int OUT_BITS    = SAMPLE_BITS + 1;
   localparam int TRIG_BITS   = 17;   // signed Q1.15 with room for +/-1.0
   localparam int MAG_BITS    = 16;   // unsigned table magnitude
   localparam int PROD_BITS   = TRIG_BITS + SAMPLE_BITS;
   localparam int SUM_BITS    = PROD_BITS + 1;
   localparam int FRAC_SHIFT  = 15;

   // oscillator phase
   localparam int TABLE_SIZE  = 256;
   localparam int PHASE_BITS  = $clog2(TABLE_SIZE);
   localparam int RATE_DIV    = 2500;
   localparam int FRAC_BITS   = $clog2(RATE_DIV);
   localparam int FREQ_BITS   = 12;
   localparam int FREQ_RESET  = 178;
   localparam int QTAB_LAST   = 64;
   localparam int QIDX_BITS   = 7;

   // increment split into table index and fraction of one index step
   localparam int INCR_RESET  = FREQ_RESET * TABLE_SIZE;
   localparam int IDX_RESET   = (INCR_RESET / RATE_DIV) % TABLE_SIZE;
   localparam int FRAC_RESET  = INCR_RESET % RATE_DIV;

   // reciprocal of RATE_DIV for the increment split
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP       = (1 << RECIP_SHIFT) / RATE_DIV;
   localparam int RECIP_BITS  = 16;
   localparam int RPROD_BITS  = FREQ_BITS + RECIP_BITS;
   localparam int QEST_LSB    = RECIP_SHIFT - PHASE_BITS;
   localparam int QEST_BITS   = RPROD_BITS - QEST_LSB;
   localparam int SCALED_BITS = FREQ_BITS + PHASE_BITS;
   localparam int REM_BITS    = SCALED_BITS + 1;

   // sin(k*pi/128) in Q1.15, k = 0..64
   function automatic logic [MAG_BITS-1:0] quarter_sine(input logic [QIDX_BITS-1:0] k);
      logic [MAG_BITS-1:0] v;
      case (k)
         7'd0:  v = 16'd0;     7'd1:  v = 16'd804;   7'd2:  v = 16'd1608;
         7'd3:  v = 16'd2411;  7'd4:  v = 16'd3212;  7'd5:  v = 16'd4011;
         7'd6:  v = 16'd4808;  7'd7:  v = 16'd5602;  7'd8:  v = 16'd6393;
         7'd9:  v = 16'd7180;  7'd10: v = 16'd7962;  7'd11: v = 16'd8740;
         7'd12: v = 16'd9512;  7'd13: v = 16'd10279; 7'd14: v = 16'd11039;
         7'd15: v = 16'd11793; 7'd16: v = 16'd12540; 7'd17: v = 16'd13279;
         7'd18: v = 16'd14010; 7'd19: v = 16'd14733; 7'd20: v = 16'd15447;
         7'd21: v = 16'd16151; 7'd22: v = 16'd16846; 7'd23: v = 16'd17531;
         7'd24: v = 16'd18205; 7'd25: v = 16'd18868; 7'd26: v = 16'd19520;
         7'd27: v = 16'd20160; 7'd28: v = 16'd20788; 7'd29: v = 16'd21403;
         7'd30: v = 16'd22006; 7'd31: v = 16'd22595; 7'd32: v = 16'd23170;
         7'd33: v = 16'd23732; 7'd34: v = 16'd24279; 7'd35: v = 16'd24812;
         7'd36: v = 16'd25330; 7'd37: v = 16'd25833; 7'd38: v = 16'd26320;
         7'd39: v = 16'd26791; 7'd40: v = 16'd27246; 7'd41: v = 16'd27684;
         7'd42: v = 16'd28106; 7'd43: v = 16'd28511; 7'd44: v = 16'd28899;
         7'd45: v = 16'd29269; 7'd46: v = 16'd29622; 7'd47: v = 16'd29957;
         7'd48: v = 16'd30274; 7'd49: v = 16'd30572; 7'd50: v = 16'd30853;
         7'd51: v = 16'd31114; 7'd52: v = 16'd31357; 7'd53: v = 16'd31581;
         7'd54: v = 16'd31786; 7'd55: v = 16'd31972; 7'd56: v = 16'd32138;
         7'd57: v = 16'd32286; 7'd58: v = 16'd32413; 7'd59: v = 16'd32522;
         7'd60: v = 16'd32610; 7'd61: v = 16'd32679; 7'd62: v = 16'd32729;
         7'd63: v = 16'd32758; 7'd64: v = 16'd32768;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // full-wave sine from the quarter table: fold odd quadrants, negate upper half
   function automatic logic signed [TRIG_BITS-1:0] sine_at(input logic [PHASE_BITS-1:0] p);
      logic [1:0]              quad;
      logic [PHASE_BITS-3:0]   r;
      logic [QIDX_BITS-1:0]    k;
      logic [TRIG_BITS-1:0]    mag;
      quad = p[PHASE_BITS-1 -: 2];
      r    = p[PHASE_BITS-3:0];
      if (quad[0]) begin
         k = QIDX_BITS'(QTAB_LAST) - QIDX_BITS'(r);
      end else begin
         k = QIDX_BITS'(r);
      end
      mag = TRIG_BITS'(quarter_sine(k));
      if (quad[1]) begin
         return -$signed(mag);
      end else begin
         return $signed(mag);
      end
   endfunction

endpackage

// ===== sv/ncofs_req_if.sv =====
// ----------------------------------------------------------------------------
// ncofs_req_if: input sample channel
// Valid/ready channel carrying one complex sample and the block start flag.
// ----------------------------------------------------------------------------
interface ncofs_req_if;
   logic                                           valid;
   logic                                           ready;
   logic signed [ncofs_pkg::SAMPLE_BITS-1:0]       in_real;
   logic signed [ncofs_pkg::SAMPLE_BITS-1:0]       in_imag;
   logic                                           block_start;

   modport source (output valid, output in_real, output in_imag, output block_start,
                   input ready);
   modport sink   (input valid, input in_real, input in_imag, input block_start,
                   output ready);
endinterface

// ===== sv/ncofs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ncofs_rsp_if: result sample channel
// Valid/ready channel carrying one frequency shifted complex sample.
// ----------------------------------------------------------------------------
interface ncofs_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [ncofs_pkg::OUT_BITS-1:0]      out_real;
   logic signed [ncofs_pkg::OUT_BITS-1:0]      out_imag;

   modport source (output valid, output out_real, output out_imag, input ready);
   modport sink   (input valid, input out_real, input out_imag, output ready);
endinterface

// ===== sv/ncofs_phase.sv =====
// ----------------------------------------------------------------------------
// ncofs_phase: oscillator phase accumulator
// Holds the phase as a table index plus a fraction below RATE_DIV, and the
// per-sample increment split the same way when the frequency is written.
// ----------------------------------------------------------------------------
module ncofs_phase (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ncofs_pkg::FREQ_BITS-1:0]     csr_wdata,
   input  logic                                advance,
   input  logic                                block_start,
   output logic [ncofs_pkg::PHASE_BITS-1:0]    phase_idx
);

   logic [ncofs_pkg::PHASE_BITS-1:0]   idx_ff, idx_in;
   logic [ncofs_pkg::FRAC_BITS-1:0]    frac_ff, frac_in;
   logic [ncofs_pkg::PHASE_BITS-1:0]   incr_idx_ff, incr_idx_in;
   logic [ncofs_pkg::FRAC_BITS-1:0]    incr_frac_ff, incr_frac_in;

   logic [ncofs_pkg::SCALED_BITS-1:0]  freq_scaled;
   logic [ncofs_pkg::RPROD_BITS-1:0]   recip_prod;
   logic [ncofs_pkg::QEST_BITS-1:0]    q_est;
   logic [ncofs_pkg::REM_BITS-1:0]     q_prod;
   logic [ncofs_pkg::REM_BITS-1:0]     rem_est;
   logic                               rem_fix;

   logic [ncofs_pkg::PHASE_BITS-1:0]   base_idx;
   logic [ncofs_pkg::FRAC_BITS-1:0]    base_frac;
   logic [ncofs_pkg::FRAC_BITS:0]      frac_sum;
   logic                               frac_carry;

   // split freq*TABLE_SIZE into index and fraction: reciprocal estimate, one fixup
   always_comb begin
      freq_scaled  = {csr_wdata, ncofs_pkg::PHASE_BITS'(0)};
      recip_prod   = ncofs_pkg::RPROD_BITS'(csr_wdata)
                   * ncofs_pkg::RPROD_BITS'(ncofs_pkg::RECIP);
      q_est        = recip_prod[ncofs_pkg::RPROD_BITS-1:ncofs_pkg::QEST_LSB];
      q_prod       = ncofs_pkg::REM_BITS'(q_est) * ncofs_pkg::REM_BITS'(ncofs_pkg::RATE_DIV);
      rem_est      = ncofs_pkg::REM_BITS'(freq_scaled) - q_prod;
      rem_fix      = (rem_est >= ncofs_pkg::REM_BITS'(ncofs_pkg::RATE_DIV));
      if (rem_fix) begin
         incr_frac_in = ncofs_pkg::FRAC_BITS'(rem_est - ncofs_pkg::REM_BITS'(ncofs_pkg::RATE_DIV));
      end else begin
         incr_frac_in = ncofs_pkg::FRAC_BITS'(rem_est);
      end
      incr_idx_in  = q_est[ncofs_pkg::PHASE_BITS-1:0] + ncofs_pkg::PHASE_BITS'(rem_fix);
   end

   // phase used by this beat, and the phase for the next one
   always_comb begin
      base_idx   = block_start ? '0 : idx_ff;
      base_frac  = block_start ? '0 : frac_ff;
      frac_sum   = {1'b0, base_frac} + {1'b0, incr_frac_ff};
      frac_carry = (frac_sum >= (ncofs_pkg::FRAC_BITS+1)'(ncofs_pkg::RATE_DIV));
      if (frac_carry) begin
         frac_in = ncofs_pkg::FRAC_BITS'(frac_sum
                 - (ncofs_pkg::FRAC_BITS+1)'(ncofs_pkg::RATE_DIV));
      end else begin
         frac_in = ncofs_pkg::FRAC_BITS'(frac_sum);
      end
      idx_in     = base_idx + incr_idx_ff + ncofs_pkg::PHASE_BITS'(frac_carry);
      phase_idx  = base_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         frac_ff      <= '0;
         incr_idx_ff  <= ncofs_pkg::PHASE_BITS'(ncofs_pkg::IDX_RESET);
         incr_frac_ff <= ncofs_pkg::FRAC_BITS'(ncofs_pkg::FRAC_RESET);
      end else begin
         if (advance) begin
            idx_ff  <= idx_in;
            frac_ff <= frac_in;
         end
         if (csr_we) begin
            incr_idx_ff  <= incr_idx_in;
            incr_frac_ff <= incr_frac_in;
         end
      end
   end

endmodule

// ===== sv/ncofs_mixer.sv =====
// ----------------------------------------------------------------------------
// ncofs_mixer: complex mixer datapath
// Input register holds sample plus sine/cosine; complex multiply, rounding
// and saturation feed the result register. Two-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
module ncofs_mixer (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic signed [ncofs_pkg::SAMPLE_BITS-1:0]    in_real,
   input  logic signed [ncofs_pkg::SAMPLE_BITS-1:0]    in_imag,
   input  logic [ncofs_pkg::PHASE_BITS-1:0]            phase_idx,
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output logic signed [ncofs_pkg::OUT_BITS-1:0]       out_real,
   output logic signed [ncofs_pkg::OUT_BITS-1:0]       out_imag
);

   localparam int RND_BITS = ncofs_pkg::SUM_BITS - ncofs_pkg::FRAC_SHIFT;

   logic                                        s1_valid_ff, s1_valid_in;
   logic                                        out_valid_ff, out_valid_in;
   logic signed [ncofs_pkg::SAMPLE_BITS-1:0]    i_ff, q_ff;
   logic signed [ncofs_pkg::TRIG_BITS-1:0]      cos_ff, sin_ff;
   logic signed [ncofs_pkg::OUT_BITS-1:0]       re_ff, re_in;
   logic signed [ncofs_pkg::OUT_BITS-1:0]       im_ff, im_in;

   logic                                        out_free;
   logic                                        accept;
   logic                                        s1_move;
   logic signed [ncofs_pkg::TRIG_BITS-1:0]      cos_in, sin_in;
   logic signed [ncofs_pkg::PROD_BITS-1:0]      p_ci, p_sq, p_cq, p_si;
   logic signed [ncofs_pkg::SUM_BITS-1:0]       sum_re, sum_im;
   logic signed [ncofs_pkg::SUM_BITS-1:0]       shr_re, shr_im;

   // saturate a rounded value into the result width
   function automatic logic signed [ncofs_pkg::OUT_BITS-1:0] sat_out(
      input logic signed [RND_BITS-1:0] v);
      logic signed [RND_BITS-1:0] hi;
      logic signed [RND_BITS-1:0] lo;
      hi = RND_BITS'((1 << (ncofs_pkg::OUT_BITS-1)) - 1);
      lo = -hi - RND_BITS'(1);
      if (v > hi) begin
         return ncofs_pkg::OUT_BITS'(hi);
      end else if (v < lo) begin
         return ncofs_pkg::OUT_BITS'(lo);
      end else begin
         return ncofs_pkg::OUT_BITS'(v);
      end
   endfunction

   // handshake: result register frees first, input register follows
   always_comb begin
      out_free     = !out_valid_ff || out_ready;
      in_ready     = !s1_valid_ff || out_free;
      accept       = in_valid && in_ready;
      s1_move      = s1_valid_ff && out_free;
      s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = out_free ? s1_valid_ff : out_valid_ff;
   end

   // oscillator lookup for the accepted beat; cosine is a quarter turn ahead
   always_comb begin
      sin_in = ncofs_pkg::sine_at(phase_idx);
      cos_in = ncofs_pkg::sine_at(phase_idx
             + ncofs_pkg::PHASE_BITS'(ncofs_pkg::TABLE_SIZE / 4));
   end

   // multiply by conjugate oscillator, round half up after the Q15 shift
   always_comb begin
      p_ci   = cos_ff * i_ff;
      p_sq   = sin_ff * q_ff;
      p_cq   = cos_ff * q_ff;
      p_si   = sin_ff * i_ff;
      sum_re = ncofs_pkg::SUM_BITS'(p_ci) + ncofs_pkg::SUM_BITS'(p_sq)
             + ncofs_pkg::SUM_BITS'(1 << (ncofs_pkg::FRAC_SHIFT-1));
      sum_im = ncofs_pkg::SUM_BITS'(p_cq) - ncofs_pkg::SUM_BITS'(p_si)
             + ncofs_pkg::SUM_BITS'(1 << (ncofs_pkg::FRAC_SHIFT-1));
      shr_re = sum_re >>> ncofs_pkg::FRAC_SHIFT;
      shr_im = sum_im >>> ncofs_pkg::FRAC_SHIFT;
      re_in  = sat_out(shr_re[RND_BITS-1:0]);
      im_in  = sat_out(shr_im[RND_BITS-1:0]);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         i_ff   <= in_real;
         q_ff   <= in_imag;
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
      if (s1_move) begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_real  = re_ff;
   assign out_imag  = im_ff;

endmodule

// ===== sv/nco_complex_frequency_shift_top.sv =====
// ----------------------------------------------------------------------------
// nco_complex_frequency_shift_top: complex NCO frequency shifter
// Mixes each I/Q sample with the conjugate of a table-driven oscillator.
// ----------------------------------------------------------------------------
// Takes one complex sample per clock and returns one shifted sample per
// sample; each accepted beat is held first in the input register (sample
// plus looked-up sine and cosine) and then in the result register
// (complex multiply, round, saturate). Throughput is one beat per
// cycle while the result side keeps up. The oscillator advances by
// shift_freq*256/2500 table steps per accepted beat; block_start puts the
// current beat at phase zero. A write on the csr port sets shift_freq and
// applies from the next accepted beat; reset loads 178.
module nco_complex_frequency_shift_top (
   input  logic                                clock,
   input  logic                                reset,
   ncofs_req_if.sink                           req_ch,
   ncofs_rsp_if.source                         rsp_ch,
   input  logic                                csr_we,
   input  logic [ncofs_pkg::FREQ_BITS-1:0]     csr_wdata
);

   logic                               req_accept;
   logic [ncofs_pkg::PHASE_BITS-1:0]   phase_idx;

   assign req_accept = req_ch.valid && req_ch.ready;

   // phase accumulator and frequency register
   ncofs_phase u_phase (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .advance     (req_accept),
      .block_start (req_ch.block_start),
      .phase_idx   (phase_idx)
   );

   // mixer pipeline
   ncofs_mixer u_mixer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_real   (req_ch.in_real),
      .in_imag   (req_ch.in_imag),
      .phase_idx (phase_idx),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_real  (rsp_ch.out_real),
      .out_imag  (rsp_ch.out_imag)
   );

endmodule

// ===== tb/sv/tb_nco_complex_frequency_shift_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nco_complex_frequency_shift_top: self-checking bench for the NCO shifter
// Drives I/Q beats in random bursts, stalls the result side on its own
// pattern, and checks every result against an in-bench oscillator/mixer
// predictor across several shift_freq settings, the extremes among them.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic signed [ncofs_pkg::OUT_BITS-1:0] re;
   logic signed [ncofs_pkg::OUT_BITS-1:0] im;
} shifted_sample_type;

// predicts the mixer output and holds results still owed by the block
class shift_scoreboard;
   int unsigned        freq;
   int unsigned        phase_acc;
   int                 quarter_mag[ncofs_pkg::QTAB_LAST+1];
   shifted_sample_type owed[$];
   int                 failures;

   function new();
      freq      = ncofs_pkg::FREQ_RESET;
      phase_acc = 0;
      failures  = 0;
      quarter_mag = '{
         0, 804, 1608, 2411, 3212, 4011, 4808, 5602, 6393, 7180, 7962, 8740,
         9512, 10279, 11039, 11793, 12540, 13279, 14010, 14733, 15447, 16151,
         16846, 17531, 18205, 18868, 19520, 20160, 20788, 21403, 22006, 22595,
         23170, 23732, 24279, 24812, 25330, 25833, 26320, 26791, 27246, 27684,
         28106, 28511, 28899, 29269, 29622, 29957, 30274, 30572, 30853, 31114,
         31357, 31581, 31786, 31972, 32138, 32286, 32413, 32522, 32610, 32679,
         32729, 32758, 32768};
   endfunction

   function void set_freq(int unsigned f);
      freq = f;
   endfunction

   function int pending();
      return owed.size();
   endfunction

   // full-wave sine: fold odd quadrants, negate the upper half
   function int osc_sine(int unsigned p);
      int unsigned quarter;
      int unsigned quad;
      int unsigned r;
      int          mag;
      quarter = ncofs_pkg::TABLE_SIZE / 4;
      p       = p % ncofs_pkg::TABLE_SIZE;
      quad    = p / quarter;
      r       = p % quarter;
      mag     = (quad % 2 == 1) ? quarter_mag[quarter - r] : quarter_mag[r];
      return (quad >= 2) ? -mag : mag;
   endfunction

   // round to nearest after the Q1.15 shift, then clamp to the output range
   function logic signed [ncofs_pkg::OUT_BITS-1:0] round_clamp(longint x);
      longint y;
      longint hi;
      hi = (longint'(1) <<< (ncofs_pkg::OUT_BITS - 1)) - 1;
      y  = (x + 16384) >>> ncofs_pkg::FRAC_SHIFT;
      if (y > hi) y = hi;
      if (y < -hi - 1) y = -hi - 1;
      return ncofs_pkg::OUT_BITS'(y);
   endfunction

   // one accepted beat: mix with the conjugate oscillator, then advance phase
   function void note_sample(logic signed [ncofs_pkg::SAMPLE_BITS-1:0] re,
                             logic signed [ncofs_pkg::SAMPLE_BITS-1:0] im,
                             logic bs);
      int unsigned        modulus;
      int unsigned        phase;
      longint             s;
      longint             c;
      longint             xi;
      longint             xq;
      shifted_sample_type exp_beat;
      modulus = ncofs_pkg::TABLE_SIZE * ncofs_pkg::RATE_DIV;
      if (bs) phase_acc = 0;
      phase_acc = phase_acc % modulus;
      phase = phase_acc / ncofs_pkg::RATE_DIV;
      s  = osc_sine(phase);
      c  = osc_sine(phase + ncofs_pkg::TABLE_SIZE / 4);
      xi = re;
      xq = im;
      exp_beat.re = round_clamp(c * xi + s * xq);
      exp_beat.im = round_clamp(c * xq - s * xi);
      owed.push_back(exp_beat);
      phase_acc = (phase_acc + (freq * ncofs_pkg::TABLE_SIZE) % modulus) % modulus;
   endfunction

   function void check_result(logic signed [ncofs_pkg::OUT_BITS-1:0] re,
                              logic signed [ncofs_pkg::OUT_BITS-1:0] im);
      shifted_sample_type exp_beat;
      if (owed.size() == 0) begin
         $error("unexpected result beat: out_real %0d, out_imag %0d", re, im);
         failures++;
         return;
      end
      exp_beat = owed.pop_front();
      if (re !== exp_beat.re) begin
         $error("out_real mismatch: expected %0d, actual %0d", exp_beat.re, re);
         failures++;
      end
      if (im !== exp_beat.im) begin
         $error("out_imag mismatch: expected %0d, actual %0d", exp_beat.im, im);
         failures++;
      end
   endfunction
endclass

module tb_nco_complex_frequency_shift_top;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_type;

   localparam logic signed [ncofs_pkg::SAMPLE_BITS-1:0] S_MAX = 16'sh7fff;
   localparam logic signed [ncofs_pkg::SAMPLE_BITS-1:0] S_MIN = -16'sh8000;
   localparam int RANDOM_PHASES   = 12;
   localparam int BEATS_PER_PHASE = 150;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [ncofs_pkg::FREQ_BITS-1:0] csr_wdata = '0;

   ncofs_req_if req_ch();
   ncofs_rsp_if rsp_ch();

   shift_scoreboard sb;
   int              burst_left = 0;
   stall_mode_type  stall_mode = STALL_NONE;
   int              mode_left = 0;
   int              stall_left = 0;

   nco_complex_frequency_shift_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #5000000;
      $display("nco_complex_frequency_shift_top regression: fail");
      $finish;
   end

   // result side: ready pattern changes mode at random intervals
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            mode_left  = $urandom_range(20, 80);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE: begin
               rsp_ch.ready <= 1'b1;
            end
            STALL_RANDOM: begin
               rsp_ch.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_ch.ready <= 1'b0;
               end else if ($urandom_range(0, 3) == 0) begin
                  stall_left = $urandom_range(1, 12);
                  rsp_ch.ready <= 1'b0;
               end else begin
                  rsp_ch.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // check every result beat
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result(rsp_ch.out_real, rsp_ch.out_imag);
      end
   end

   // mostly uniform samples, some full-scale and near-zero corners
   function automatic logic signed [ncofs_pkg::SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return $urandom_range(0, 1) ? 16'sd0 : -16'sd1;
         default: return ncofs_pkg::SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // one input beat; called and returns at a falling edge
   task automatic send_sample(input logic signed [ncofs_pkg::SAMPLE_BITS-1:0] re,
                              input logic signed [ncofs_pkg::SAMPLE_BITS-1:0] im,
                              input logic bs);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.in_real     <= re;
      req_ch.in_imag     <= im;
      req_ch.block_start <= bs;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_sample(re, im, bs);
      @(negedge clock);
   endtask

   // frequency write once the pipe has drained
   task automatic write_freq(input int unsigned f);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (sb.pending() != 0);
      csr_we    <= 1'b1;
      csr_wdata <= ncofs_pkg::FREQ_BITS'(f);
      @(posedge clock);
      sb.set_freq(f);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int unsigned f;
      sb = new();
      req_ch.valid       = 1'b0;
      req_ch.in_real     = '0;
      req_ch.in_imag     = '0;
      req_ch.block_start = 1'b0;
      rsp_ch.ready       = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset frequency, full-scale corners
      send_sample(S_MAX, S_MAX, 1'b1);
      send_sample(S_MIN, S_MIN, 1'b0);
      send_sample(S_MAX, S_MIN, 1'b0);
      send_sample(S_MIN, S_MAX, 1'b0);
      send_sample(16'sd0, 16'sd0, 1'b0);
      send_sample(-16'sd1, -16'sd1, 1'b0);
      send_sample(16'sd1, -16'sd1, 1'b0);

      // quarter-turn steps: every quadrant and the top table entry
      write_freq(625);
      send_sample(S_MIN, S_MAX, 1'b1);
      for (int k = 0; k < 8; k++) begin
         send_sample((k % 2) ? S_MAX : S_MIN, (k % 3) ? S_MIN : S_MAX, 1'b0);
      end

      // frozen oscillator
      write_freq(0);
      send_sample(S_MAX, S_MIN, 1'b0);
      send_sample(S_MIN, S_MIN, 1'b1);
      send_sample(S_MAX, S_MAX, 1'b0);

      // register above the rate divider: aliased increment
      write_freq(4095);
      send_sample(S_MIN, S_MAX, 1'b1);
      send_sample(S_MAX, S_MAX, 1'b0);
      send_sample(S_MIN, S_MIN, 1'b0);
      send_sample(16'sd12345, -16'sd23456, 1'b0);

      // increment of exactly one full turn
      write_freq(ncofs_pkg::RATE_DIV);
      send_sample(S_MAX, S_MIN, 1'b0);
      send_sample(S_MIN, S_MAX, 1'b0);

      // random phases at assorted frequencies
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0)
            f = ncofs_pkg::RATE_DIV - 1;
         else if (ph == 1)
            f = 1;
         else if ($urandom_range(0, 5) == 0)
            f = $urandom_range(ncofs_pkg::RATE_DIV, (1 << ncofs_pkg::FREQ_BITS) - 1);
         else
            f = $urandom_range(0, ncofs_pkg::RATE_DIV - 1);
         write_freq(f);
         repeat (BEATS_PER_PHASE) begin
            send_sample(pick_sample(), pick_sample(), 1'($urandom_range(0, 19) == 0));
         end
      end

      // drain
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.failures == 0) begin
         $display("nco_complex_frequency_shift_top regression: pass");
      end else begin
         $display("nco_complex_frequency_shift_top regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ncofs_pkg.sv
sv/ncofs_req_if.sv
sv/ncofs_rsp_if.sv
sv/ncofs_phase.sv
sv/ncofs_mixer.sv
sv/nco_complex_frequency_shift_top.sv
tb/sv/tb_nco_complex_frequency_shift_top.sv
